// ----- hdl/p1305_pkg.sv -----
// Poly1305 authenticator: shared types, constants and the controller command set.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package p1305_pkg;

	localparam int LimbW   = 26;
	localparam int AccW    = 27;
	localparam int HW      = 28;
	localparam int RW      = 26;
	localparam int SW      = 29;
	localparam int DW      = 64;
	localparam int CW      = 38;
	localparam int NLimb   = 5;
	localparam int IdxW    = 3;
	localparam int CfgAw   = 5;
	localparam int CfgDw   = 64;

	localparam logic [LimbW-1:0] LIMB_MASK = 26'h3ffffff;
	localparam logic [AccW-1:0]  TOP_BIT   = 27'd16777216;

	// key clamp, one mask per 26-bit limb of r
	localparam logic [RW-1:0] CLAMP [NLimb] = '{
		26'h3ffffff, 26'h3ffff03, 26'h3ffc0ff, 26'h3f03fff, 26'h00fffff
	};

	// register indexes
	localparam logic [1:0] REG_R_LOW    = 2'd0;
	localparam logic [1:0] REG_R_HIGH   = 2'd1;
	localparam logic [1:0] REG_PAD_LOW  = 2'd2;
	localparam logic [1:0] REG_PAD_HIGH = 2'd3;

	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
		logic [4:0]  byte_count;
		logic        last_block;
		logic        mode;
		logic [63:0] expected_low;
		logic [63:0] expected_high;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] tag_low;
		logic [63:0] tag_high;
		logic        tag_mismatch;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_MUL, ST_CARRY, ST_FOLD, ST_FLOAD, ST_SELECT, ST_TAG
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_LATCH, OP_LOAD, OP_MUL, OP_CARRY, OP_FOLD, OP_FLOAD, OP_SELECT
	} op_t;

	typedef struct packed {
		op_t             op;
		logic            emit;
		logic [IdxW-1:0] i;
		logic [IdxW-1:0] j;
	} cmd_t;

	typedef struct packed {
		logic has_block;
		logic last;
		logic out_busy;
	} status_t;

endpackage

// ----- hdl/poly1305_mac_top.sv -----
// Poly1305 one-time authenticator, top level with key registers on the APB port.
// A block is accepted, loaded, then runs 25 limb products, 5 carries and 1 fold;
// a last item adds the final reduction; the single limb multiplier sets the rate.
// A new item is taken only once the last is through; a count-zero item skips the products.
// Reset: arst_n clears key registers, accumulator and output valid asynchronously.
// Depends on p1305_pkg, p1305_ctrl, p1305_dp.
`timescale 1ns / 1ps
module poly1305_mac_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  p1305_pkg::in_beat_t            in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output p1305_pkg::out_beat_t           out_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [p1305_pkg::CfgAw-1:0]    paddr,
	input  logic [p1305_pkg::CfgDw-1:0]    pwdata,
	output logic [p1305_pkg::CfgDw-1:0]    prdata,
	output logic                           pready
);

	logic [63:0] r_low_q, r_high_q, pad_low_q, pad_high_q;
	p1305_pkg::cmd_t    cmd;
	p1305_pkg::status_t stat;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && (paddr[2:0] == 3'd0);

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q    <= '0;
			r_high_q   <= '0;
			pad_low_q  <= '0;
			pad_high_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				p1305_pkg::REG_R_LOW:    r_low_q    <= pwdata;
				p1305_pkg::REG_R_HIGH:   r_high_q   <= pwdata;
				p1305_pkg::REG_PAD_LOW:  pad_low_q  <= pwdata;
				p1305_pkg::REG_PAD_HIGH: pad_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (reg_idx)
			p1305_pkg::REG_R_LOW:    prdata = r_low_q;
			p1305_pkg::REG_R_HIGH:   prdata = r_high_q;
			p1305_pkg::REG_PAD_LOW:  prdata = pad_low_q;
			p1305_pkg::REG_PAD_HIGH: prdata = pad_high_q;
			default:                 prdata = '0;
		endcase
	end

	p1305_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	p1305_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.key_r     ({r_high_q, r_low_q}),
		.key_s     ({pad_high_q, pad_low_q}),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hdl/p1305_ctrl.sv -----
// Poly1305 controller: sequences load, limb products, carries and final reduction.
// Depends on p1305_pkg; drives p1305_dp through cmd_t and reads status_t.
`timescale 1ns / 1ps
module p1305_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  p1305_pkg::status_t   stat,
	output p1305_pkg::cmd_t      cmd
);

	p1305_pkg::state_t state_q, state_d;
	logic [p1305_pkg::IdxW-1:0] i_q, i_d, j_q, j_d;
	logic fin_q, fin_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= p1305_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			fin_q   <= fin_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		fin_d    = fin_q;
		in_ready = 1'b0;
		cmd.op   = p1305_pkg::OP_NONE;
		cmd.emit = 1'b0;
		cmd.i    = i_q;
		cmd.j    = j_q;
		case (state_q)
			p1305_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = p1305_pkg::OP_LATCH;
					state_d = p1305_pkg::ST_START;
				end
			end
			p1305_pkg::ST_START: begin
				fin_d = 1'b0;
				if (stat.has_block) begin
					cmd.op  = p1305_pkg::OP_LOAD;
					i_d     = '0;
					j_d     = '0;
					state_d = p1305_pkg::ST_MUL;
				end else if (stat.last) begin
					state_d = p1305_pkg::ST_FLOAD;
				end else begin
					state_d = p1305_pkg::ST_IDLE;
				end
			end
			p1305_pkg::ST_MUL: begin
				cmd.op = p1305_pkg::OP_MUL;
				if (j_q == 3'd4) begin
					j_d = '0;
					if (i_q == 3'd4) begin
						i_d     = '0;
						state_d = p1305_pkg::ST_CARRY;
					end else begin
						i_d = i_q + 3'd1;
					end
				end else begin
					j_d = j_q + 3'd1;
				end
			end
			p1305_pkg::ST_CARRY: begin
				cmd.op = p1305_pkg::OP_CARRY;
				if (i_q == 3'd4) begin
					i_d     = '0;
					state_d = p1305_pkg::ST_FOLD;
				end else begin
					i_d = i_q + 3'd1;
				end
			end
			p1305_pkg::ST_FOLD: begin
				cmd.op = p1305_pkg::OP_FOLD;
				if (fin_q)
					state_d = p1305_pkg::ST_SELECT;
				else if (stat.last)
					state_d = p1305_pkg::ST_FLOAD;
				else
					state_d = p1305_pkg::ST_IDLE;
			end
			p1305_pkg::ST_FLOAD: begin
				// final carry pass starts at limb one
				cmd.op  = p1305_pkg::OP_FLOAD;
				fin_d   = 1'b1;
				i_d     = 3'd1;
				state_d = p1305_pkg::ST_CARRY;
			end
			p1305_pkg::ST_SELECT: begin
				cmd.op  = p1305_pkg::OP_SELECT;
				state_d = p1305_pkg::ST_TAG;
			end
			p1305_pkg::ST_TAG: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					fin_d    = 1'b0;
					state_d  = p1305_pkg::ST_IDLE;
				end
			end
			default: state_d = p1305_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/p1305_dp.sv -----
// Poly1305 datapath: accumulator limbs, one limb product per cycle, carries, tag.
// Depends on p1305_pkg; commanded by p1305_ctrl.
`timescale 1ns / 1ps
module p1305_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  p1305_pkg::cmd_t      cmd,
	output p1305_pkg::status_t   stat,
	input  p1305_pkg::in_beat_t  in_data,
	input  logic [127:0]         key_r,
	input  logic [127:0]         key_s,
	output logic                 out_valid,
	input  logic                 out_ready,
	output p1305_pkg::out_beat_t out_data
);

	logic [127:0] blk_q, exp_q;
	logic         top_q, last_q, mode_q, has_q;
	logic [p1305_pkg::AccW-1:0] acc_q [p1305_pkg::NLimb];
	logic [p1305_pkg::HW-1:0]   h_q   [p1305_pkg::NLimb];
	logic [p1305_pkg::RW-1:0]   r_q   [p1305_pkg::NLimb];
	logic [p1305_pkg::SW-1:0]   s_q   [p1305_pkg::NLimb];
	logic [p1305_pkg::DW-1:0]   d_q   [p1305_pkg::NLimb];
	logic [p1305_pkg::CW-1:0]   c_q;
	logic                       out_valid_q;
	p1305_pkg::out_beat_t       out_q;

	// block padding from the byte count
	logic [127:0] full_blk, pad_blk, one_bit;
	logic [6:0]   bitpos;
	always_comb begin
		full_blk = {in_data.block_high, in_data.block_low};
		bitpos   = {in_data.byte_count[3:0], 3'b000};
		one_bit  = 128'd1 << bitpos;
		pad_blk  = (full_blk & (one_bit - 128'd1)) | one_bit;
	end

	// key limbs clamped, message limbs
	logic [129:0] r_ext, b_ext;
	logic [p1305_pkg::RW-1:0] r_lmb [p1305_pkg::NLimb];
	logic [p1305_pkg::LimbW-1:0] b_lmb [p1305_pkg::NLimb];
	always_comb begin
		r_ext = {2'b00, key_r};
		b_ext = {2'b00, blk_q};
		for (int k = 0; k < p1305_pkg::NLimb; k++) begin
			r_lmb[k] = r_ext[k*26 +: 26] & p1305_pkg::CLAMP[k];
			b_lmb[k] = b_ext[k*26 +: 26];
		end
	end

	// one limb product: h[j] times r[i-j] or 5*r[i+5-j]
	logic [3:0] wrap_idx;
	logic [p1305_pkg::SW-1:0] coef;
	logic [56:0] prod;
	always_comb begin
		wrap_idx = {1'b0, cmd.i} + 4'd5 - {1'b0, cmd.j};
		if (cmd.j <= cmd.i)
			coef = {3'b000, r_q[cmd.i - cmd.j]};
		else
			coef = s_q[wrap_idx[2:0]];
		prod = {29'd0, h_q[cmd.j]} * {28'd0, coef};
	end

	// carry step and fold
	logic [p1305_pkg::DW-1:0] csum;
	logic [41:0] fold_t;
	always_comb begin
		csum   = d_q[cmd.i] + {26'd0, c_q};
		fold_t = {15'd0, acc_q[0]} + ({4'd0, c_q} * 42'd5);
	end

	// conditional subtraction of 2^130-5
	logic [p1305_pkg::AccW-1:0] g [p1305_pkg::NLimb];
	logic [p1305_pkg::AccW:0] gs;
	logic [p1305_pkg::AccW-1:0] gc;
	logic use_g;
	always_comb begin
		gc = 27'd5;
		for (int k = 0; k < 4; k++) begin
			gs   = {1'b0, acc_q[k]} + {1'b0, gc};
			g[k] = {1'b0, gs[25:0]};
			gc   = {25'd0, gs[27:26]};
		end
		g[4]  = acc_q[4] + gc;
		use_g = g[4] >= 27'(1 << 26);
		if (use_g)
			g[4] = g[4] - 27'(1 << 26);
	end

	// tag packing and pad add
	logic [63:0] lo, hi;
	logic [127:0] tag;
	always_comb begin
		lo  = {37'd0, acc_q[0]} | ({37'd0, acc_q[1]} << 26) | ({37'd0, acc_q[2]} << 52);
		hi  = ({37'd0, acc_q[2]} >> 12) | ({37'd0, acc_q[3]} << 14)
			| ({37'd0, acc_q[4]} << 40);
		tag = {hi, lo} + key_s;
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.op == p1305_pkg::OP_LATCH) begin
			blk_q  <= (in_data.byte_count >= 5'd16) ? full_blk : pad_blk;
			top_q  <= in_data.byte_count >= 5'd16;
			has_q  <= in_data.byte_count != 5'd0;
			last_q <= in_data.last_block;
			mode_q <= in_data.mode;
			exp_q  <= {in_data.expected_high, in_data.expected_low};
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			p1305_pkg::OP_LOAD: begin
				// the top limb also takes bit 128 of a full block
				for (int k = 0; k < p1305_pkg::NLimb; k++) begin
					h_q[k] <= {1'b0, acc_q[k]} + {2'b00, b_lmb[k]}
						+ ((k == p1305_pkg::NLimb - 1 && top_q)
							? {1'b0, p1305_pkg::TOP_BIT} : 28'd0);
					r_q[k] <= r_lmb[k];
					s_q[k] <= {3'b000, r_lmb[k]} + {1'b0, r_lmb[k], 2'b00};
				end
				c_q <= '0;
			end
			p1305_pkg::OP_MUL: begin
				if (cmd.j == 3'd0)
					d_q[cmd.i] <= {7'd0, prod};
				else
					d_q[cmd.i] <= d_q[cmd.i] + {7'd0, prod};
			end
			p1305_pkg::OP_CARRY: c_q <= csum[63:26];
			p1305_pkg::OP_FLOAD: begin
				for (int k = 0; k < p1305_pkg::NLimb; k++)
					d_q[k] <= {37'd0, acc_q[k]};
				c_q <= '0;
			end
			default: ;
		endcase
	end

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < p1305_pkg::NLimb; k++)
				acc_q[k] <= '0;
		end else if (cmd.emit) begin
			for (int k = 0; k < p1305_pkg::NLimb; k++)
				acc_q[k] <= '0;
		end else begin
			case (cmd.op)
				p1305_pkg::OP_CARRY: acc_q[cmd.i] <= {1'b0, csum[25:0]};
				p1305_pkg::OP_FOLD: begin
					acc_q[0] <= {1'b0, fold_t[25:0]};
					acc_q[1] <= acc_q[1] + {11'd0, fold_t[41:26]};
				end
				p1305_pkg::OP_SELECT: begin
					if (use_g)
						for (int k = 0; k < p1305_pkg::NLimb; k++)
							acc_q[k] <= g[k];
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.tag_low      <= tag[63:0];
			out_q.tag_high     <= tag[127:64];
			out_q.tag_mismatch <= mode_q && (tag != exp_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.has_block = has_q;
	assign stat.last     = last_q;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

// ----- hdl/p1305_chk.sv -----
// Port-level checks for the Poly1305 authenticator, bound to the top level.
// Depends on p1305_pkg and poly1305_mac_top.
`timescale 1ns / 1ps
module p1305_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input p1305_pkg::out_beat_t out_data,
	input logic                 pready
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one item at a time: input closes after a beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// a new result never appears right after an input beat
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// config port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind poly1305_mac_top p1305_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.pready    (pready)
);

// ----- sim/poly1305_mac_top_tb.sv -----
// Testbench for poly1305_mac_top: directed table then random messages, checked against
// an in-bench 130-bit Poly1305 predictor. Depends on p1305_pkg and poly1305_mac_top.
`timescale 1ns / 1ps
module poly1305_mac_top_tb;

	// 2^130 - 5
	localparam logic [129:0] PRIME   = {2'b11, {124{1'b1}}, 4'b1011};
	localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		p1305_pkg::in_beat_t  beat;
		bit                   typed;
		p1305_pkg::out_beat_t tag;
	} dir_row_t;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	p1305_pkg::in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	p1305_pkg::out_beat_t out_data;
	logic      psel = 0, penable = 0, pwrite = 0;
	logic [p1305_pkg::CfgAw-1:0] paddr = '0;
	logic [p1305_pkg::CfgDw-1:0] pwdata = '0;
	logic [p1305_pkg::CfgDw-1:0] prdata;
	logic      pready;

	// predictor state: key words and fully reduced accumulator
	logic [63:0]  key_word [4];
	logic [129:0] acc_h;
	p1305_pkg::out_beat_t tag_q [$];
	dir_row_t     dir_rows [$];
	int           mismatches = 0;
	bit           hold_req = 0;
	bit           quiet = 0;

	poly1305_mac_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// one Poly1305 step on accumulator h; returns 1 when a tag comes out
	function automatic bit mac_step(input p1305_pkg::in_beat_t b, inout logic [129:0] h,
			output p1305_pkg::out_beat_t res);
		logic [130:0] msg;
		logic [127:0] data;
		logic [127:0] r;
		logic [259:0] prod;
		logic [127:0] tag;
		int unsigned  nbits;
		msg = '0;
		res = '0;
		if (b.byte_count >= 16) begin
			msg = {3'b001, b.block_high, b.block_low};
		end else if (b.byte_count != 0) begin
			nbits = 8 * b.byte_count;
			data = {b.block_high, b.block_low} & ((128'd1 << nbits) - 128'd1);
			msg = {3'b000, data | (128'd1 << nbits)};
		end
		if (b.byte_count != 0) begin
			r = {key_word[p1305_pkg::REG_R_HIGH], key_word[p1305_pkg::REG_R_LOW]} & R_CLAMP;
			prod = ({129'd0, msg} + {130'd0, h}) * {132'd0, r};
			for (int k = 0; k < 3; k++)
				prod = {130'd0, prod[129:0]} + prod[259:130] * 260'd5;
			for (int k = 0; k < 2; k++)
				if (prod >= {130'd0, PRIME}) prod = prod - {130'd0, PRIME};
			h = prod[129:0];
		end
		if (!b.last_block) return 0;
		tag = h[127:0] + {key_word[p1305_pkg::REG_PAD_HIGH], key_word[p1305_pkg::REG_PAD_LOW]};
		res.tag_low = tag[63:0];
		res.tag_high = tag[127:64];
		res.tag_mismatch = b.mode && (tag != {b.expected_high, b.expected_low});
		h = '0;
		return 1;
	endfunction

	// result checker
	always @(posedge clk) begin
		p1305_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tag_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected tag beat %h", out_data);
			end else begin
				want = tag_q.pop_front();
				if (out_data.tag_low !== want.tag_low || out_data.tag_high !== want.tag_high
						|| out_data.tag_mismatch !== want.tag_mismatch) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tag mismatch: exp %h_%h/%b got %h_%h/%b",
							want.tag_high, want.tag_low, want.tag_mismatch,
							out_data.tag_high, out_data.tag_low, out_data.tag_mismatch);
				end
			end
		end
	end

	// receiver: random stalls, quiet stretches, one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid && !hold_req);
		end
	end

	// send one beat after a gap; predicts at acceptance
	task automatic send_beat(input p1305_pkg::in_beat_t b, input int gap, input bit typed,
			input p1305_pkg::out_beat_t typed_tag);
		p1305_pkg::out_beat_t res;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		if (mac_step(b, acc_h, res)) tag_q.push_back(typed ? typed_tag : res);
	endtask

	task automatic drain();
		if (in_valid) in_valid <= 0;
		while (tag_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup then access; the bus is released by the caller
	task automatic write_key(input logic [1:0] idx, input logic [63:0] value);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 3'b000}; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		key_word[idx] = value;
	endtask

	task automatic load_key(input logic [63:0] rl, rh, pl, ph);
		drain();
		write_key(p1305_pkg::REG_R_LOW, rl);
		write_key(p1305_pkg::REG_R_HIGH, rh);
		write_key(p1305_pkg::REG_PAD_LOW, pl);
		write_key(p1305_pkg::REG_PAD_HIGH, ph);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic p1305_pkg::in_beat_t mk_beat(input logic [63:0] lo, hi, input int cnt,
			input bit last, mode, input logic [63:0] elo, ehi);
		p1305_pkg::in_beat_t b;
		b.block_low = lo; b.block_high = hi; b.byte_count = cnt[4:0];
		b.last_block = last; b.mode = mode;
		b.expected_low = elo; b.expected_high = ehi;
		return b;
	endfunction

	task automatic add_row(input p1305_pkg::in_beat_t b, input bit typed,
			input p1305_pkg::out_beat_t t);
		dir_row_t row;
		row.beat = b; row.typed = typed; row.tag = t;
		dir_rows.push_back(row);
	endtask

	function automatic p1305_pkg::in_beat_t rand_beat(input bit last);
		p1305_pkg::in_beat_t b;
		int cnt;
		logic [129:0] h_copy;
		p1305_pkg::out_beat_t res;
		if (last) cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
			: $urandom_range(0, 16);
		else cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : 16;
		b = mk_beat(rand64(), rand64(), cnt, last, $urandom_range(0, 1), rand64(), rand64());
		// half of the checks carry the right tag
		if (last && b.mode && $urandom_range(0, 1)) begin
			h_copy = acc_h;
			void'(mac_step(b, h_copy, res));
			b.expected_low = res.tag_low;
			b.expected_high = res.tag_high;
		end
		return b;
	endfunction

	// random messages of 1..6 beats, with random gaps between beats
	task automatic send_messages(input int n_beats);
		int sent;
		int len;
		sent = 0;
		while (sent < n_beats) begin
			len = $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				send_beat(rand_beat(k == len - 1), quiet ? 0 : $urandom_range(0, 7), 0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		p1305_pkg::out_beat_t none;
		p1305_pkg::out_beat_t t;
		logic [63:0] ones;
		none = '0;
		ones = '1;
		for (int k = 0; k < 4; k++) key_word[k] = '0;
		acc_h = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero key after reset: every tag is zero
		t = '0;
		add_row(mk_beat(0, 0, 0, 1, 0, 0, 0), 1, t);
		add_row(mk_beat(ones, ones, 16, 1, 1, 0, 0), 1, t);
		t.tag_mismatch = 1;
		add_row(mk_beat(ones, ones, 16, 1, 1, ones, ones), 1, t);
		foreach (dir_rows[k])
			send_beat(dir_rows[k].beat, $urandom_range(0, 3), dir_rows[k].typed,
				dir_rows[k].tag);
		dir_rows.delete();

		// extreme key, then special cases through the predictor
		load_key(ones, ones, ones, ones);
		add_row(mk_beat(0, 0, 0, 1, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 16, 0, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 16, 1, 1, ones, ones), 0, none);
		add_row(mk_beat(ones, ones, 31, 1, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 17, 1, 1, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 1, 1, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 8, 1, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 15, 1, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 7, 0, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 9, 0, 0, 0, 0), 0, none);
		add_row(mk_beat(ones, ones, 0, 0, 0, 0, 0), 0, none);
		add_row(mk_beat(0, 0, 16, 1, 1, 0, 0), 0, none);
		add_row(mk_beat(0, 0, 3, 1, 0, 0, 0), 0, none);
		foreach (dir_rows[k])
			send_beat(dir_rows[k].beat, $urandom_range(0, 3), 0, none);

		// random phases over several keys
		load_key(rand64(), rand64(), rand64(), rand64());
		send_messages(130);
		load_key(0, 0, ones, ones);
		quiet = 1;
		send_messages(100);
		// long output hold-off while last beats keep coming
		drain();
		hold_req = 1;
		for (int k = 0; k < 8; k++) send_beat(rand_beat(1), 0, 0, none);
		quiet = 0;
		load_key(ones, 0, 0, ones);
		send_messages(130);
		// key change in the middle of a message
		load_key(rand64(), rand64(), rand64(), rand64());
		for (int k = 0; k < 3; k++) send_beat(rand_beat(0), $urandom_range(0, 7), 0, none);
		load_key(rand64(), rand64(), rand64(), rand64());
		send_beat(rand_beat(1), 0, 0, none);
		send_messages(260);

		drain();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- poly1305_mac_top.f -----
hdl/p1305_pkg.sv
hdl/p1305_ctrl.sv
hdl/p1305_dp.sv
hdl/poly1305_mac_top.sv
hdl/p1305_chk.sv
sim/poly1305_mac_top_tb.sv
